// File: src/multi_base_timer_bank_top_defines.svh
// Assertion macros used by the timer bank controller.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef MULTI_BASE_TIMER_BANK_TOP_DEFINES_SVH
`define MULTI_BASE_TIMER_BANK_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBTB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timer bank check failed");

// The consequent must hold in the cycle after the antecedent.
`define MBTB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timer bank check failed");

`endif

// File: src/mbtb_pkg.sv
package mbtb_pkg;

   localparam int NUM_BASES  = 4;
   localparam int BASE_W     = 2;
   localparam int RELOAD_W   = 16;
   localparam int ID_W       = 6;
   localparam int FUNC_W     = 2;
   localparam int KIND_W     = 2;
   localparam int MAX_EVENTS = 16;
   localparam int EV_W       = 5;

   localparam logic [RELOAD_W-1:0] RELOAD_RESET [NUM_BASES] =
      '{16'd1, 16'd10, 16'd100, 16'd1000};

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_SET   = 2'd1,
      FUNC_CHECK = 2'd2
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_SET    = 2'd0,
      KIND_CHECK  = 2'd1,
      KIND_EXPIRY = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OUT_EVENT = 2'd0,
      OUT_SET   = 2'd1,
      OUT_CHECK = 2'd2
   } out_sel_type;

   typedef struct packed {
      logic              latch_req;
      logic [BASE_W-1:0] base_sel;
      logic              base_dec;
      logic              base_reload;
      logic              rd_en;
      logic              wr_en;
      logic              addr_sel_id;
      logic [ID_W-1:0]   walk_addr;
      logic              pend_load;
      logic              pend_clear;
      logic              out_load;
      out_sel_type       out_sel;
      logic              out_last;
   } cmd_type;

   typedef struct packed {
      logic base_fire;
      logic rd_nonzero;
      logic rd_expire;
      logic id_valid;
      logic pend_valid;
      logic out_free;
   } sts_type;

endpackage

// File: src/multi_base_timer_bank_top.sv
// Bank of 4*TIMERS_PER_BASE down-count timers in four groups, each group paced by
// its own base counter reloaded from the reload_base registers (csr_index 0 to 3).
// A tick item steps the four base counters; each group whose counter runs out is
// walked slot by slot through the single-port timer memory, counting every nonzero
// timer down and giving an expiry item (kind 2) for each timer that reaches zero
// with notify set, at most 16 per tick, the final one marked by rsp_last. A tick
// with no expiry gives no result. A set item (kind 0) loads timeout and notify and
// answers with flag set when the id names a timer; a check item (kind 1) answers
// with flag set when the timer is at zero, which a never-set timer is. Items are
// taken one at a time: a set passes through ST_SET and a check through ST_CHK_RD
// and ST_CHK_ANS until the result is registered; a tick passes through ST_BASE
// once per base counter and closes in ST_FINAL, with an ST_READ memory read and
// an ST_UPDATE step per timer of each group whose base runs out, writing back
// each nonzero count; a stall on the result side can hold the steps that load a result.
// A finished result waits in the output register while the next item is taken.
module multi_base_timer_bank_top
   import mbtb_pkg::*;
#(
   parameter int TIMERS_PER_BASE = 4,
   parameter int COUNT_WIDTH     = 32
) (
   input  logic                clock,
   input  logic                reset,
   // Configuration writes.
   input  logic                csr_wr_en,
   input  logic [BASE_W-1:0]   csr_index,
   input  logic [RELOAD_W-1:0] csr_wr_data,
   // Request items.
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [ID_W-1:0]     req_timer_id,
   input  logic [31:0]         req_timeout_value,
   input  logic                req_notify_enable,
   // Result items.
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [ID_W-1:0]     rsp_timer_index,
   output logic                rsp_flag,
   output logic                rsp_last
);

   cmd_type cmd;
   sts_type sts;

   // The controller sequences ticks, sets and checks.
   mbtb_controller #(
      .TIMERS_PER_BASE(TIMERS_PER_BASE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath holds the base counters, timer memory and output register.
   mbtb_datapath #(
      .TIMERS_PER_BASE(TIMERS_PER_BASE),
      .COUNT_WIDTH    (COUNT_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_timer_id      (req_timer_id),
      .req_timeout_value (req_timeout_value),
      .req_notify_enable (req_notify_enable),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_timer_index   (rsp_timer_index),
      .rsp_flag          (rsp_flag),
      .rsp_last          (rsp_last)
   );

endmodule

// File: src/mbtb_datapath.sv
module mbtb_datapath
   import mbtb_pkg::*;
#(
   parameter int TIMERS_PER_BASE = 4,
   parameter int COUNT_WIDTH     = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [BASE_W-1:0]   csr_index,
   input  logic [RELOAD_W-1:0] csr_wr_data,
   input  logic [ID_W-1:0]     req_timer_id,
   input  logic [31:0]         req_timeout_value,
   input  logic                req_notify_enable,
   input  cmd_type             cmd,
   output sts_type             sts,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [ID_W-1:0]     rsp_timer_index,
   output logic                rsp_flag,
   output logic                rsp_last
);

   localparam int NUM_TIMERS = NUM_BASES * TIMERS_PER_BASE;
   localparam int IDX_W      = $clog2(NUM_TIMERS);

   // Base counters and their reload registers.
   logic [RELOAD_W-1:0] reload_ff   [NUM_BASES];
   logic [RELOAD_W-1:0] reload_in   [NUM_BASES];
   logic [RELOAD_W-1:0] base_cnt_ff [NUM_BASES];
   logic [RELOAD_W-1:0] base_cnt_in [NUM_BASES];

   always_comb begin
      for (int b = 0; b < NUM_BASES; b++) begin
         reload_in[b]   = reload_ff[b];
         base_cnt_in[b] = base_cnt_ff[b];
         if (csr_wr_en && (csr_index == BASE_W'(b))) begin
            reload_in[b] = csr_wr_data;
         end
         if (cmd.base_sel == BASE_W'(b)) begin
            if (cmd.base_dec) begin
               base_cnt_in[b] = base_cnt_ff[b] - RELOAD_W'(1);
            end else if (cmd.base_reload) begin
               base_cnt_in[b] = reload_ff[b];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < NUM_BASES; b++) begin
         if (reset) begin
            reload_ff[b]   <= RELOAD_RESET[b];
            base_cnt_ff[b] <= RELOAD_RESET[b];
         end else begin
            reload_ff[b]   <= reload_in[b];
            base_cnt_ff[b] <= base_cnt_in[b];
         end
      end
   end

   assign sts.base_fire = (base_cnt_ff[cmd.base_sel] <= RELOAD_W'(1));

   // Latched request payload.
   logic [ID_W-1:0]        id_ff;
   logic [COUNT_WIDTH-1:0] timeout_ff;
   logic                   notify_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         id_ff      <= req_timer_id;
         timeout_ff <= req_timeout_value[COUNT_WIDTH-1:0];
         notify_ff  <= req_notify_enable;
      end
   end

   assign sts.id_valid = ({1'b0, id_ff} < (ID_W+1)'(NUM_TIMERS));

   // Timer memory: each word holds the notify flag above the count. Entries
   // not yet written read as zero through their valid bits.
   logic [COUNT_WIDTH:0]   mem [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]  vld_ff;
   logic [COUNT_WIDTH:0]   rd_ff;
   logic                   rd_vld_ff;
   logic [IDX_W-1:0]       addr;
   logic [COUNT_WIDTH:0]   wdata;
   logic [COUNT_WIDTH-1:0] cnt;
   logic                   ntf;
   logic [COUNT_WIDTH-1:0] cnt_dec;

   assign addr    = cmd.addr_sel_id ? id_ff[IDX_W-1:0] : cmd.walk_addr[IDX_W-1:0];
   assign cnt     = rd_vld_ff ? rd_ff[COUNT_WIDTH-1:0] : '0;
   assign ntf     = rd_vld_ff & rd_ff[COUNT_WIDTH];
   assign cnt_dec = cnt - COUNT_WIDTH'(1);
   assign wdata   = cmd.addr_sel_id ? {notify_ff, timeout_ff} : {ntf, cnt_dec};

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[addr] <= wdata;
      end
      if (cmd.rd_en) begin
         rd_ff     <= mem[addr];
         rd_vld_ff <= vld_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.wr_en) begin
         vld_ff[addr] <= 1'b1;
      end
   end

   assign sts.rd_nonzero = (cnt != '0);
   assign sts.rd_expire  = (cnt == COUNT_WIDTH'(1)) && ntf;

   // One held expiry event, so that the final event of a tick can carry last.
   logic            pend_valid_ff;
   logic            pend_valid_in;
   logic [ID_W-1:0] pend_idx_ff;

   assign pend_valid_in = cmd.pend_load | (pend_valid_ff & ~cmd.pend_clear);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pend_load) begin
         pend_idx_ff <= cmd.walk_addr;
      end
   end

   assign sts.pend_valid = pend_valid_ff;

   // Output register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic [ID_W-1:0]   rsp_idx_ff;
   logic              rsp_flag_ff;
   logic              rsp_last_ff;

   assign sts.out_free = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_last_ff <= cmd.out_last;
         case (cmd.out_sel)
            OUT_SET: begin
               rsp_kind_ff <= KIND_SET;
               rsp_idx_ff  <= id_ff;
               rsp_flag_ff <= sts.id_valid;
            end
            OUT_CHECK: begin
               rsp_kind_ff <= KIND_CHECK;
               rsp_idx_ff  <= id_ff;
               rsp_flag_ff <= sts.id_valid & (cnt == '0);
            end
            default: begin
               rsp_kind_ff <= KIND_EXPIRY;
               rsp_idx_ff  <= pend_idx_ff;
               rsp_flag_ff <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_timer_index = rsp_idx_ff;
   assign rsp_flag        = rsp_flag_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// File: src/mbtb_controller.sv
`include "multi_base_timer_bank_top_defines.svh"

module mbtb_controller
   import mbtb_pkg::*;
#(
   parameter int TIMERS_PER_BASE = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   output logic              req_stall,
   output cmd_type           cmd,
   input  sts_type           sts
);

   localparam int SLOT_W = (TIMERS_PER_BASE > 1) ? $clog2(TIMERS_PER_BASE) : 1;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_BASE    = 8'b0000_0010,
      ST_READ    = 8'b0000_0100,
      ST_UPDATE  = 8'b0000_1000,
      ST_FINAL   = 8'b0001_0000,
      ST_SET     = 8'b0010_0000,
      ST_CHK_RD  = 8'b0100_0000,
      ST_CHK_ANS = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [ID_W-1:0]   walk_ff, walk_in;
   logic [EV_W-1:0]   ev_cnt_ff, ev_cnt_in;
   logic              accept;
   logic              expire;
   logic              hold;
   logic              last_slot;
   logic              last_base;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign expire    = sts.rd_expire & (ev_cnt_ff < EV_W'(MAX_EVENTS));
   assign hold      = expire & sts.pend_valid & ~sts.out_free;
   assign last_slot = (slot_ff == SLOT_W'(TIMERS_PER_BASE - 1));
   assign last_base = (base_ff == BASE_W'(NUM_BASES - 1));

   always_comb begin
      state_in  = state_ff;
      base_in   = base_ff;
      slot_in   = slot_ff;
      walk_in   = walk_ff;
      ev_cnt_in = ev_cnt_ff;

      cmd             = '0;
      cmd.out_sel     = OUT_EVENT;
      cmd.base_sel    = base_ff;
      cmd.walk_addr   = walk_ff;
      cmd.latch_req   = accept;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_TICK: begin
                     state_in  = ST_BASE;
                     base_in   = '0;
                     ev_cnt_in = '0;
                  end
                  FUNC_SET:   state_in = ST_SET;
                  FUNC_CHECK: state_in = ST_CHK_RD;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_BASE: begin
            if (sts.base_fire) begin
               cmd.base_reload = 1'b1;
               slot_in  = '0;
               walk_in  = ID_W'(int'(base_ff) * TIMERS_PER_BASE);
               state_in = ST_READ;
            end else begin
               cmd.base_dec = 1'b1;
               if (last_base) begin
                  state_in = ST_FINAL;
               end else begin
                  base_in = base_ff + BASE_W'(1);
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!hold) begin
               cmd.wr_en = sts.rd_nonzero;
               if (expire) begin
                  cmd.pend_load = 1'b1;
                  ev_cnt_in     = ev_cnt_ff + EV_W'(1);
                  if (sts.pend_valid) begin
                     cmd.out_load = 1'b1;
                     cmd.out_sel  = OUT_EVENT;
                     cmd.out_last = 1'b0;
                  end
               end
               if (last_slot) begin
                  if (last_base) begin
                     state_in = ST_FINAL;
                  end else begin
                     base_in  = base_ff + BASE_W'(1);
                     state_in = ST_BASE;
                  end
               end else begin
                  slot_in  = slot_ff + SLOT_W'(1);
                  walk_in  = walk_ff + ID_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_FINAL: begin
            if (!sts.pend_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_sel    = OUT_EVENT;
               cmd.out_last   = 1'b1;
               cmd.pend_clear = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_SET: begin
            cmd.addr_sel_id = 1'b1;
            if (sts.out_free) begin
               cmd.wr_en    = sts.id_valid;
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_SET;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CHK_RD: begin
            cmd.addr_sel_id = 1'b1;
            cmd.rd_en       = 1'b1;
            state_in        = ST_CHK_ANS;
         end
         ST_CHK_ANS: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_CHECK;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         base_ff   <= '0;
         slot_ff   <= '0;
         walk_ff   <= '0;
         ev_cnt_ff <= '0;
      end else begin
         state_ff  <= state_in;
         base_ff   <= base_in;
         slot_ff   <= slot_in;
         walk_ff   <= walk_in;
         ev_cnt_ff <= ev_cnt_in;
      end
   end

   `MBTB_ASSERT_NOW(a_out_load_free, cmd.out_load, sts.out_free)
   `MBTB_ASSERT_NOW(a_no_pend_loss, cmd.pend_load && sts.pend_valid, cmd.out_load)
   `MBTB_ASSERT_NOW(a_rd_wr_excl, cmd.rd_en, !cmd.wr_en)
   `MBTB_ASSERT_NOW(a_ev_bound, 1'b1, ev_cnt_ff <= EV_W'(MAX_EVENTS))
   `MBTB_ASSERT_NEXT(a_tick_start, accept && (req_func == FUNC_TICK), ev_cnt_ff == '0)

endmodule

// File: tb/timer_bank_tb_pkg.sv
package timer_bank_tb_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   import mbtb_pkg::*;

   localparam int SLOTS_PER_GROUP = 4;
   localparam int TIMER_COUNT     = NUM_BASES * SLOTS_PER_GROUP;

   // The one function code that the block ignores.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      kind_type        kind;
      logic [ID_W-1:0] index;
      logic            flag;
      logic            last;
   } timer_result_type;

   class timer_bank_scoreboard;
      logic [RELOAD_W-1:0] reload_value [NUM_BASES];
      logic [RELOAD_W-1:0] base_count [NUM_BASES];
      logic [31:0]         remaining [TIMER_COUNT];
      logic                notify_on [TIMER_COUNT];
      timer_result_type    awaited [$];
      int unsigned         errors;
      int unsigned         items_seen;
      int unsigned         results_seen;
      int unsigned         expiries_seen;

      function new();
         int b;
         int t;
         for (b = 0; b < NUM_BASES; b++) begin
            reload_value[b] = RELOAD_RESET[b];
            base_count[b]   = RELOAD_RESET[b];
         end
         for (t = 0; t < TIMER_COUNT; t++) begin
            remaining[t] = '0;
            notify_on[t] = 1'b0;
         end
         errors        = 0;
         items_seen    = 0;
         results_seen  = 0;
         expiries_seen = 0;
      endfunction

      function void write_reload(int unsigned index, logic [RELOAD_W-1:0] value);
         reload_value[index] = value;
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      // Works out the results of one accepted item and queues them.
      function void note_item(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                              logic [31:0] timeout, logic notify);
         logic             known;
         timer_result_type held;
         bit               have_held;
         int               fired;
         int               b;
         int               s;
         int               t;
         known     = (id < TIMER_COUNT);
         have_held = 1'b0;
         fired     = 0;
         items_seen++;
         case (func)
            FUNC_TICK: begin
               // Events are held back by one so that the final one can carry last.
               for (b = 0; b < NUM_BASES; b++) begin
                  if (base_count[b] > 1) begin
                     base_count[b] = base_count[b] - 1'b1;
                  end else begin
                     for (s = 0; s < SLOTS_PER_GROUP; s++) begin
                        t = b * SLOTS_PER_GROUP + s;
                        if (remaining[t] != 0) begin
                           remaining[t] = remaining[t] - 1'b1;
                           if (remaining[t] == 0 && notify_on[t] && fired < MAX_EVENTS) begin
                              if (have_held) begin
                                 awaited.push_back(held);
                              end
                              held      = '{KIND_EXPIRY, ID_W'(t), 1'b1, 1'b0};
                              have_held = 1'b1;
                              fired++;
                           end
                        end
                     end
                     base_count[b] = reload_value[b];
                  end
               end
               if (have_held) begin
                  held.last = 1'b1;
                  awaited.push_back(held);
               end
            end
            FUNC_SET: begin
               if (known) begin
                  remaining[id] = timeout;
                  notify_on[id] = notify;
               end
               awaited.push_back('{KIND_SET, id, known, 1'b1});
            end
            FUNC_CHECK: begin
               awaited.push_back('{KIND_CHECK, id, known ? (remaining[id] == 0) : 1'b0, 1'b1});
            end
            default: begin
            end
         endcase
      endfunction

      function void compare_field(string field, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: result %0d, %s expected %0d, actual %0d",
                     $time, results_seen, field, want, got);
         end
      endfunction

      // Compares one accepted result with the oldest expectation.
      function void check_result(logic [KIND_W-1:0] kind, logic [ID_W-1:0] index,
                                 logic flag, logic last);
         timer_result_type want;
         results_seen++;
         if (kind == KIND_EXPIRY) begin
            expiries_seen++;
         end
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: result %0d not expected (expected none), actual kind %0d",
                     $time, results_seen, kind);
            $display("   index %0d flag %0d last %0d", index, flag, last);
            return;
         end
         want = awaited.pop_front();
         compare_field("kind", ID_W'(want.kind), ID_W'(kind));
         compare_field("timer_index", want.index, index);
         compare_field("flag", ID_W'(want.flag), ID_W'(flag));
         compare_field("last", ID_W'(want.last), ID_W'(last));
      endfunction
   endclass

endpackage

// File: tb/tb_multi_base_timer_bank_top.sv
module tb_multi_base_timer_bank_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mbtb_pkg::*;
   import timer_bank_tb_pkg::*;

   localparam int CLK_PERIOD       = 20;
   localparam int RESET_CYCLES     = 9;
   // A tick walks at most every timer of every group, a read and an update each, plus
   // the base and closing steps, so this many quiet cycles is well past any walk in flight.
   localparam int SETTLE_CYCLES    = 64;
   localparam int DRAIN_TICKS      = 100;
   localparam int PHASES           = 5;
   localparam int ITEMS_PER_PHASE  = 24;
   localparam int unsigned CYCLE_LIMIT = 600000;

   // Register indexes of the four reload registers, one per group.
   localparam logic [BASE_W-1:0] REG_RELOAD_BASE [NUM_BASES] = '{2'd0, 2'd1, 2'd2, 2'd3};

   // Per phase: sender idle and receiver stall chances in percent, and the
   // reload settings. Zero acts as one, and 65535 freezes a group for the rest
   // of the run once its counter has reloaded.
   localparam int IDLE_PCT [PHASES]  = '{0, 49, 0, 32, 32};
   localparam int STALL_PCT [PHASES] = '{0, 0, 49, 32, 32};
   localparam logic [RELOAD_W-1:0] RELOADS [PHASES][NUM_BASES] = '{
      '{16'd1, 16'd1, 16'd1, 16'd1},
      '{16'd0, 16'd2, 16'd3, 16'd1},
      '{16'd65535, 16'd1, 16'd2, 16'd0},
      '{16'd3, 16'd1, 16'd1, 16'd2},
      '{16'd2, 16'd3, 16'd1, 16'd4}
   };

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [BASE_W-1:0]   csr_index;
   logic [RELOAD_W-1:0] csr_wr_data;
   logic                req_valid;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func;
   logic [ID_W-1:0]     req_timer_id;
   logic [31:0]         req_timeout_value;
   logic                req_notify_enable;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [ID_W-1:0]     rsp_timer_index;
   logic                rsp_flag;
   logic                rsp_last;

   int                  idle_pct  = 0;
   int                  stall_pct = 0;
   int unsigned         cycles    = 0;
   timer_bank_scoreboard sb;

   multi_base_timer_bank_top #(
      .TIMERS_PER_BASE(SLOTS_PER_GROUP),
      .COUNT_WIDTH(32)
   ) dut (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   // The receiver stalls at random; its chance changes with the phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Both channels are observed at the rising edge, where the inputs have been
   // stable since the falling edge before. An accepted item is noted first so
   // that its expectations are queued behind those of older items.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_item(req_func, req_timer_id, req_timeout_value, req_notify_enable);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_kind, rsp_timer_index, rsp_flag, rsp_last);
         end
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d results outstanding",
                  cycles, sb.pending());
         $display("status: fail");
         $finish;
      end
   end

   // Offers one item, after a random number of idle cycles, and returns at the
   // falling edge after it was taken. The caller then either offers the next
   // item or lowers valid, so valid sees a single assignment per edge.
   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] id,
                            input logic [31:0] timeout, input logic notify);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_timer_id      <= id;
      req_timeout_value <= timeout;
      req_notify_enable <= notify;
      do begin
         @(posedge clock);
      end while (req_stall);
      @(negedge clock);
   endtask

   // Holds the sender back until every expected result has come, then lets the
   // block finish any tick walk that produces nothing.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes all four reload registers while the block is idle.
   task automatic program_reloads(input int phase);
      int b;
      for (b = 0; b < NUM_BASES; b++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= REG_RELOAD_BASE[b];
         csr_wr_data <= RELOADS[phase][b];
         sb.write_reload(b, RELOADS[phase][b]);
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // One random item. Ids mostly name real timers and timeouts are mostly
   // short, so that timers actually run out; now and then an id past the bank,
   // a full-width timeout or the unused function code shows up.
   task automatic random_item();
      int                pick;
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0]   id;
      logic [31:0]       timeout;
      logic              notify;
      pick    = $urandom_range(99);
      id      = ($urandom_range(9) != 0) ? ID_W'($urandom_range(TIMER_COUNT - 1))
                                         : ID_W'($urandom);
      timeout = ($urandom_range(4) == 0) ? $urandom : 32'($urandom_range(6));
      notify  = ($urandom_range(3) != 0);
      if (pick < 45) begin
         func = FUNC_TICK;
      end else if (pick < 75) begin
         func = FUNC_SET;
      end else if (pick < 96) begin
         func = FUNC_CHECK;
      end else begin
         func = FUNC_UNUSED;
      end
      send_item(func, id, timeout, notify);
   endtask

   initial begin
      int phase;
      int n;

      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = '0;
      csr_wr_data       = '0;
      req_valid         = 1'b0;
      req_func          = FUNC_TICK;
      req_timer_id      = '0;
      req_timeout_value = '0;
      req_notify_enable = 1'b0;
      sb = new();

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed items with the reload values from reset, where group 0
      // counts on every tick. Timers that were never set read as at zero, and
      // ids past the bank are refused on set and answer not-zero on check.
      send_item(FUNC_CHECK, 6'd0, 32'd0, 1'b0);
      send_item(FUNC_CHECK, 6'd15, 32'd0, 1'b0);
      send_item(FUNC_CHECK, 6'd16, 32'd0, 1'b0);
      send_item(FUNC_CHECK, 6'd63, 32'hFFFF_FFFF, 1'b1);
      send_item(FUNC_SET, 6'd63, 32'd5, 1'b1);
      send_item(FUNC_SET, 6'd16, 32'd1, 1'b1);
      // The unused function code must give no result at all.
      send_item(FUNC_UNUSED, 6'd0, 32'd1, 1'b1);
      send_item(FUNC_SET, 6'd0, 32'd1, 1'b1);
      send_item(FUNC_SET, 6'd1, 32'd2, 1'b0);
      send_item(FUNC_SET, 6'd2, 32'hFFFF_FFFF, 1'b1);
      send_item(FUNC_SET, 6'd3, 32'd0, 1'b1);
      send_item(FUNC_CHECK, 6'd0, 32'd0, 1'b0);
      // The first tick runs timer 0 out with notify set; the second runs
      // timer 1 out quietly, since its notify is clear.
      send_item(FUNC_TICK, 6'd63, 32'hFFFF_FFFF, 1'b1);
      send_item(FUNC_TICK, 6'd0, 32'd0, 1'b0);
      send_item(FUNC_CHECK, 6'd1, 32'd0, 1'b0);
      send_item(FUNC_CHECK, 6'd2, 32'd0, 1'b0);
      send_item(FUNC_CHECK, 6'd3, 32'd0, 1'b0);
      // Arm one timer in each of the slower groups and stop timer 2 again.
      send_item(FUNC_SET, 6'd4, 32'd1, 1'b1);
      send_item(FUNC_SET, 6'd8, 32'd1, 1'b1);
      send_item(FUNC_SET, 6'd15, 32'd1, 1'b1);
      send_item(FUNC_SET, 6'd2, 32'd0, 1'b0);
      settle();
      program_reloads(0);

      // A new reload value waits for the group's next reload. This run of
      // ticks brings groups 1 and 2 to their first reload, fires their armed
      // timers and leaves those bases counting on each tick. The slowest base
      // needs a thousand ticks, so group 3 keeps its reset base all run long.
      repeat (DRAIN_TICKS) send_item(FUNC_TICK, ID_W'($urandom), $urandom, 1'($urandom));

      // Every timer is armed for one count, so the next tick runs out all the
      // timers of the three faster groups at once.
      for (n = 0; n < TIMER_COUNT; n++) begin
         send_item(FUNC_SET, ID_W'(n), 32'd1, 1'b1);
      end
      send_item(FUNC_TICK, 6'd0, 32'd0, 1'b0);

      // Random phases, each with its own reload settings and idle pattern.
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            settle();
            program_reloads(phase);
         end
         idle_pct  = IDLE_PCT[phase];
         stall_pct = STALL_PCT[phase];
         repeat (ITEMS_PER_PHASE) random_item();
      end

      settle();
      $display("run covered %0d items and %0d results, %0d of them expiry events,",
               sb.items_seen, sb.results_seen, sb.expiries_seen);
      $display("over %0d reload settings with and without idle and stall cycles",
               PHASES + 1);
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: multi_base_timer_bank_top.f
+incdir+src
src/mbtb_pkg.sv
src/mbtb_datapath.sv
src/mbtb_controller.sv
src/multi_base_timer_bank_top.sv
tb/timer_bank_tb_pkg.sv
tb/tb_multi_base_timer_bank_top.sv
